FILE: sv/ebl_pkg.sv
// ebl_pkg: shared types and constants of the escalating address blocklist.
// No dependencies; imported by ebl_cell, ebl_ctrl and the top level.
package ebl_pkg;

    localparam int TABLE_ENTRIES = 64;

    localparam logic [1:0] CMD_DEFAULT = 2'd0;

    localparam logic [1:0] CFG_DEFAULT_BAN = 2'd0;
    localparam logic [1:0] CFG_MAX_BAN     = 2'd1;
    localparam logic [1:0] CFG_MAX_WATCH   = 2'd2;

    localparam logic [2:0] ST_ALREADY   = 3'd0;
    localparam logic [2:0] ST_BANNED    = 3'd1;
    localparam logic [2:0] ST_ESCALATED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TICK      = 3'd4;

    typedef enum logic [1:0] {
        OP_SEARCH,
        OP_INSERT,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_INSERT,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [15:0] default_ban;
        logic [15:0] max_ban;
        logic [15:0] max_watch;
    } t_cfg;

    // token that walks the cell chain
    typedef struct packed {
        logic        valid;
        t_op         op;
        logic        done;
        logic        free_seen;
        logic [2:0]  status;
        logic [31:0] addr;
        logic [15:0] block;
        logic [15:0] applied;
    } t_tok;

endpackage

FILE: sv/ebl_cell.sv
// ebl_cell: one table entry of the blocklist; updates its entry as the token passes.
// Depends on ebl_pkg.
module ebl_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ebl_pkg::t_cfg i_cfg,
    input  ebl_pkg::t_tok i_tok,
    output ebl_pkg::t_tok o_tok
);
    import ebl_pkg::*;

    logic [31:0] r_addr;
    logic        r_ban, r_watch;
    logic [15:0] r_ban_left, r_watch_left, r_last;
    t_tok        r_tok;

    logic [31:0] n_addr;
    logic        n_ban, n_watch;
    logic [15:0] n_ban_left, n_watch_left, n_last;
    t_tok        n_tok;

    logic        w_used;
    logic [16:0] w_twice;
    logic [16:0] w_esc;
    logic [15:0] w_esc_blk;
    logic [15:0] w_watch_len;
    logic [15:0] w_ban_dec;

    assign w_used      = r_ban | r_watch;
    assign w_twice     = {r_last, 1'b0};
    assign w_esc       = (w_twice > {1'b0, i_tok.block}) ? w_twice : {1'b0, i_tok.block};
    assign w_esc_blk   = (w_esc < {1'b0, i_cfg.max_ban}) ? w_esc[15:0] : i_cfg.max_ban;
    assign w_watch_len = (w_twice < {1'b0, i_cfg.max_watch}) ? w_twice[15:0] : i_cfg.max_watch;
    assign w_ban_dec   = (r_ban_left != 16'd0) ? r_ban_left - 16'd1 : r_ban_left;

    always_comb begin
        n_addr       = r_addr;
        n_ban        = r_ban;
        n_watch      = r_watch;
        n_ban_left   = r_ban_left;
        n_watch_left = r_watch_left;
        n_last       = r_last;
        n_tok        = i_tok;
        if (i_tok.valid) begin
            case (i_tok.op)
                OP_TICK: begin
                    if (r_watch) begin
                        if (r_watch_left != 16'd0) begin
                            n_watch_left = r_watch_left - 16'd1;
                        end
                        if (n_watch_left == 16'd0) begin
                            n_watch = 1'b0;
                        end
                    end
                    if (r_ban) begin
                        n_ban_left = w_ban_dec;
                        if (w_ban_dec == 16'd0) begin
                            n_ban = 1'b0;
                            if (w_watch_len == 16'd0) begin
                                n_watch      = 1'b0;
                                n_watch_left = 16'd0;
                            end else begin
                                n_watch      = 1'b1;
                                n_watch_left = w_watch_len;
                            end
                        end
                    end
                end
                OP_SEARCH: begin
                    if (!w_used) begin
                        n_tok.free_seen = 1'b1;
                    end else if (!i_tok.done && r_addr == i_tok.addr) begin
                        n_tok.done = 1'b1;
                        if (r_ban) begin
                            n_tok.status  = ST_ALREADY;
                            n_tok.applied = 16'd0;
                        end else begin
                            n_tok.status  = ST_ESCALATED;
                            n_tok.applied = w_esc_blk;
                            n_last        = w_esc_blk;
                            n_ban_left    = w_esc_blk;
                            if (w_esc_blk == 16'd0) begin
                                // zero ban ends at once with a zero watch
                                n_ban        = 1'b0;
                                n_watch      = 1'b0;
                                n_watch_left = 16'd0;
                            end else begin
                                n_ban = 1'b1;
                            end
                        end
                    end
                end
                OP_INSERT: begin
                    if (!i_tok.done && !w_used) begin
                        n_tok.done   = 1'b1;
                        n_addr       = i_tok.addr;
                        n_ban        = 1'b1;
                        n_ban_left   = i_tok.block;
                        n_last       = i_tok.block;
                        n_watch      = 1'b0;
                        n_watch_left = 16'd0;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ban       <= 1'b0;
            r_watch     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_ban   <= n_ban;
            r_watch <= n_watch;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_ban_left   <= n_ban_left;
        r_watch_left <= n_watch_left;
        r_last       <= n_last;
    end

    assign o_tok = r_tok;

endmodule

FILE: sv/ebl_ctrl.sv
// ebl_ctrl: handshakes, configuration registers, token launch and result decode.
// Depends on ebl_pkg.
module ebl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_cmd,
    input  logic [31:0]   i_ip_address,
    input  logic [15:0]   i_ban_minutes,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_status,
    output logic [15:0]   o_applied_minutes,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output ebl_pkg::t_cfg o_cfg,
    output ebl_pkg::t_tok o_head,
    input  ebl_pkg::t_tok i_tail
);
    import ebl_pkg::*;

    t_state      r_state, n_state;
    t_cfg        r_cfg;
    t_tok        r_head, n_head;
    logic [2:0]  r_res_status, n_res_status;
    logic [15:0] r_res_min, n_res_min;
    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [15:0] r_out_min;

    logic        w_load_out, w_need_insert;
    logic [15:0] w_base, w_block;
    logic [2:0]  w_status;
    logic [15:0] w_min;

    assign w_base  = (i_cmd == CMD_DEFAULT) ? r_cfg.default_ban : i_ban_minutes;
    assign w_block = (w_base < r_cfg.max_ban) ? w_base : r_cfg.max_ban;

    assign w_need_insert = (i_tail.op == OP_SEARCH) && !i_tail.done
                           && (i_tail.block != 16'd0) && i_tail.free_seen;

    always_comb begin
        if (i_tail.op == OP_TICK) begin
            w_status = ST_TICK;
            w_min    = 16'd0;
        end else if (i_tail.done) begin
            w_status = i_tail.status;
            w_min    = i_tail.applied;
        end else if (i_tail.block == 16'd0) begin
            w_status = ST_BANNED;
            w_min    = 16'd0;
        end else if (!i_tail.free_seen) begin
            w_status = ST_FULL;
            w_min    = 16'd0;
        end else begin
            w_status = ST_BANNED;
            w_min    = i_tail.block;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_tail.valid) begin
                    n_state = w_need_insert ? S_INSERT : S_HOLD;
                end
            end
            S_INSERT: begin
                if (i_tail.valid) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        w_load_out   = 1'b0;
        o_stall      = 1'b1;
        n_head       = r_head;
        n_head.valid = 1'b0;
        n_res_status = r_res_status;
        n_res_min    = r_res_min;
        case (r_state)
            S_IDLE: begin
                o_stall  = 1'b0;
                if (i_valid) begin
                    n_head.valid     = 1'b1;
                    n_head.op        = i_cmd[1] ? OP_TICK : OP_SEARCH;
                    n_head.done      = 1'b0;
                    n_head.free_seen = 1'b0;
                    n_head.status    = ST_BANNED;
                    n_head.addr      = i_ip_address;
                    n_head.block     = w_block;
                    n_head.applied   = 16'd0;
                end
            end
            S_RUN: begin
                if (i_tail.valid) begin
                    n_res_status = w_status;
                    n_res_min    = w_min;
                    if (w_need_insert) begin
                        n_head       = i_tail;
                        n_head.op    = OP_INSERT;
                        n_head.done  = 1'b0;
                    end
                end
            end
            S_INSERT: begin
                n_head.valid = 1'b0;
            end
            S_HOLD: begin
                w_load_out = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_head.valid      <= 1'b0;
            r_out_valid       <= 1'b0;
            r_cfg.default_ban <= 16'd10;
            r_cfg.max_ban     <= 16'd1440;
            r_cfg.max_watch   <= 16'd2880;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DEFAULT_BAN: r_cfg.default_ban <= i_cfg_data;
                    CFG_MAX_BAN:     r_cfg.max_ban     <= i_cfg_data;
                    CFG_MAX_WATCH:   r_cfg.max_watch   <= i_cfg_data;
                    default: begin
                        r_cfg <= r_cfg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_min    <= n_res_min;
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_min    <= r_res_min;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_applied_minutes = r_out_min;
    assign o_cfg_ready       = 1'b1;
    assign o_cfg             = r_cfg;
    assign o_head            = r_head;

endmodule

FILE: sv/escalating_address_blocklist.sv
// escalating_address_blocklist: top level, a controller and a chain of TABLE_ENTRIES cells.
// Depends on ebl_pkg, ebl_cell and ebl_ctrl.
//
// Input channel (i_valid / o_stall): one word per request, i_cmd 0 = add with the
// default ban, 1 = add with i_ban_minutes, 2 or 3 = one-minute tick.
// Output channel (o_valid / i_stall): one word per request, o_status and
// o_applied_minutes.
// Config channel (i_cfg_valid / o_cfg_ready): i_cfg_index 0 default ban,
// 1 max ban, 2 max watch; index 3 is ignored. Write only while idle.
// Each request sends a token down the cell chain, one cell per cycle, so the
// chain length N = TABLE_ENTRIES sets the latency: a tick or an add of a listed
// address takes one pass; an add of a new address with a nonzero ban takes a
// second pass to claim the first free cell, if there is one.
// One request is in flight at a time; the next is accepted once the result
// has moved to the output register, even while that word is still stalled.
// While i_stall is high a valid output word holds and a finished result waits.
// Reset clears every entry and loads the register defaults 10, 1440, 2880.
module escalating_address_blocklist (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_ip_address,
    input  logic [15:0] i_ban_minutes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_applied_minutes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ebl_pkg::*;

    t_cfg w_cfg;
    t_tok w_tok [0:TABLE_ENTRIES];

    ebl_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_ip_address      (i_ip_address),
        .i_ban_minutes     (i_ban_minutes),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_applied_minutes (o_applied_minutes),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_cfg             (w_cfg),
        .o_head            (w_tok[0]),
        .i_tail            (w_tok[TABLE_ENTRIES])
    );

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ebl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_cfg),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule
